// ===== rtl/core/dnst_pkg.sv =====
package dnst_pkg;

   // Field widths fixed by the interface
   localparam int LIMIT_W = 9;
   localparam int ADDR_W  = 8;
   localparam int CHAR_W  = 8;
   localparam int STAT_W  = 3;
   localparam int USED_W  = 10;
   localparam int LEN_W   = 9;

   // Result slots for one text character (room for all it can cause), and the count width for them
   localparam int MAX_RES = 5;
   localparam int CNT_W   = 3;

   localparam logic [USED_W-1:0] CHARS_MAX = 10'd1023;

   // Input action codes
   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // Result kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Finish status codes
   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd1;
   localparam logic [STAT_W-1:0] ST_LONG_LABEL = 3'd2;
   localparam logic [STAT_W-1:0] ST_BAD_ESC    = 3'd3;
   localparam logic [STAT_W-1:0] ST_LONG_NAME  = 3'd4;

   // Characters with a meaning of their own
   localparam logic [CHAR_W-1:0] CH_DOT       = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A      = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z      = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOW_A     = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_Z     = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_HYPHEN    = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_USCORE    = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DEL       = 8'h7F;
   localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

   // Parser phase, one-hot
   typedef enum logic [5:0] {
      PH_START = 6'b000001,
      PH_DOT   = 6'b000010,
      PH_LABEL = 6'b000100,
      PH_ESC0  = 6'b001000,
      PH_ESC1  = 6'b010000,
      PH_ESC2  = 6'b100000
   } phase_type;

   // One input item
   typedef struct packed {
      logic              action;
      logic [CHAR_W-1:0] text_char;
   } item_type;

   // One result item
   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] wire_addr;
      logic [CHAR_W-1:0] wire_byte;
      logic [STAT_W-1:0] status;
      logic [USED_W-1:0] chars_used;
      logic [LEN_W-1:0]  wire_length;
      logic              fully_qualified;
      logic              last;
   } rsp_type;

   // All results of one character, handed from the parser to the output stage
   typedef struct packed {
      logic [CNT_W-1:0]          cnt;
      rsp_type [MAX_RES-1:0]     res;
   } burst_type;

   function automatic logic is_digit(logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_name(logic [CHAR_W-1:0] c);
      return is_digit(c) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
             ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || (c == CH_HYPHEN) || (c == CH_USCORE);
   endfunction

endpackage

// ===== rtl/core/dnst_req_if.sv =====
interface dnst_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [dnst_pkg::CHAR_W-1:0]   text_char;

   modport source (output valid, action, text_char, input ready);
   modport sink   (input valid, action, text_char, output ready);
endinterface

// ===== rtl/core/dnst_rsp_if.sv =====
interface dnst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [dnst_pkg::ADDR_W-1:0]   wire_addr;
   logic [dnst_pkg::CHAR_W-1:0]   wire_byte;
   logic [dnst_pkg::STAT_W-1:0]   status;
   logic [dnst_pkg::USED_W-1:0]   chars_used;
   logic [dnst_pkg::LEN_W-1:0]    wire_length;
   logic                          fully_qualified;
   logic                          last;

   modport source (output valid, kind, wire_addr, wire_byte, status, chars_used,
                   wire_length, fully_qualified, last, input ready);
   modport sink   (input valid, kind, wire_addr, wire_byte, status, chars_used,
                   wire_length, fully_qualified, last, output ready);
endinterface

// ===== rtl/core/dnst_in_reg.sv =====
module dnst_in_reg (
   input  logic               clock,
   input  logic               reset,
   dnst_req_if.sink           req_chan,
   input  logic               take,
   output logic               item_valid,
   output dnst_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   dnst_pkg::item_type item_ff;
   dnst_pkg::item_type item_in;
   logic               accept;

   // The slot is free when empty or when the parser takes its item this cycle.
   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in          = 1'b1;
         item_in.action    = req_chan.action;
         item_in.text_char = req_chan.text_char;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/dnst_step.sv =====
module dnst_step #(
   parameter int MAX_LABEL  = 63,
   parameter int WIRE_BYTES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [dnst_pkg::LIMIT_W-1:0]  csr_wdata,
   input  logic                          item_valid,
   input  dnst_pkg::item_type            item,
   input  logic                          out_free,
   output logic                          fire,
   output dnst_pkg::burst_type           burst
);

   localparam int LBL_W = $clog2(MAX_LABEL + 2);
   localparam logic [LBL_W-1:0]             LBL_MAX  = LBL_W'(MAX_LABEL);
   localparam logic [dnst_pkg::LIMIT_W-1:0] WIRE_CAP = dnst_pkg::LIMIT_W'(WIRE_BYTES);

   // Working copy of the name state while one character is processed
   typedef struct packed {
      dnst_pkg::phase_type                      ph;
      logic [LBL_W-1:0]                         lc;
      logic [dnst_pkg::ADDR_W-1:0]              ls;
      logic [dnst_pkg::LEN_W-1:0]               wc;
      logic [dnst_pkg::USED_W-1:0]              cc;
      logic [dnst_pkg::LIMIT_W-1:0]             lim;
      logic                                     done;
      logic                                     ok;
      logic [dnst_pkg::CNT_W-1:0]               n;
      dnst_pkg::rsp_type [dnst_pkg::MAX_RES-1:0] res;
   } ctx_type;

   dnst_pkg::phase_type          phase_ff;
   logic [LBL_W-1:0]             lc_ff;
   logic [dnst_pkg::ADDR_W-1:0]  ls_ff;
   logic [dnst_pkg::LEN_W-1:0]   wc_ff;
   logic [dnst_pkg::USED_W-1:0]  cc_ff;
   logic [dnst_pkg::LIMIT_W-1:0] lim_ff;
   logic [dnst_pkg::LIMIT_W-1:0] lim_in;
   logic [dnst_pkg::CHAR_W-1:0]  held0_ff;
   logic [dnst_pkg::CHAR_W-1:0]  held0_in;
   logic [dnst_pkg::CHAR_W-1:0]  held1_ff;
   logic [dnst_pkg::CHAR_W-1:0]  held1_in;

   ctx_type                      nx;
   logic                         at_end;
   logic [dnst_pkg::CHAR_W-1:0]  ch;
   logic [dnst_pkg::USED_W-1:0]  esc_val;

   // ---------------------------------------------------------------------
   // Building blocks of one parsing step
   // ---------------------------------------------------------------------

   function automatic ctx_type f_emit(ctx_type xi, logic k, logic [7:0] addr, logic [7:0] data,
                                      logic [2:0] st, logic [9:0] used, logic [8:0] len,
                                      logic fq);
      ctx_type x;
      x = xi;
      x.res[x.n] = '{kind: k, wire_addr: addr, wire_byte: data, status: st,
                     chars_used: used, wire_length: len, fully_qualified: fq, last: 1'b0};
      x.n = x.n + 3'd1;
      return x;
   endfunction

   function automatic ctx_type f_restart(ctx_type xi);
      ctx_type x;
      x    = xi;
      x.ph = dnst_pkg::PH_START;
      x.lc = '0;
      x.ls = '0;
      x.wc = '0;
      x.cc = '0;
      return x;
   endfunction

   function automatic ctx_type f_fail(ctx_type xi, logic [2:0] st);
      ctx_type x;
      x      = f_emit(xi, dnst_pkg::KIND_FINISH, 8'd0, 8'd0, st, xi.cc, 9'd0, 1'b0);
      x      = f_restart(x);
      x.done = 1'b1;
      return x;
   endfunction

   function automatic ctx_type f_finish(ctx_type xi, logic [7:0] term, logic fq);
      ctx_type x;
      x      = f_emit(xi, dnst_pkg::KIND_FINISH, 8'd0, term, dnst_pkg::ST_OK, xi.cc, xi.wc, fq);
      x      = f_restart(x);
      x.done = 1'b1;
      return x;
   endfunction

   function automatic ctx_type f_bump(ctx_type xi, logic [2:0] k);
      ctx_type     x;
      logic [10:0] s;
      x    = xi;
      s    = {1'b0, x.cc} + {8'd0, k};
      x.cc = (s > 11'(dnst_pkg::CHARS_MAX)) ? dnst_pkg::CHARS_MAX : s[9:0];
      return x;
   endfunction

   function automatic ctx_type f_lab_inc(ctx_type xi);
      ctx_type x;
      x = xi;
      if (x.lc <= LBL_MAX) x.lc = x.lc + LBL_W'(1);
      return x;
   endfunction

   // Write one byte at the fill position unless the name is already at its limit.
   function automatic ctx_type f_append(ctx_type xi, logic [7:0] data);
      ctx_type x;
      x    = xi;
      x.ok = 1'b0;
      if (!x.done) begin
         if (x.wc >= x.lim) begin
            x = f_fail(x, dnst_pkg::ST_LONG_NAME);
         end else begin
            x    = f_emit(x, dnst_pkg::KIND_WRITE, x.wc[7:0], data, dnst_pkg::ST_OK,
                          10'd0, 9'd0, 1'b0);
            x.wc = x.wc + 9'd1;
            x.ok = 1'b1;
         end
      end
      return x;
   endfunction

   // Patch the open label's length byte and finish the name.
   function automatic ctx_type f_close(ctx_type xi, logic [7:0] term);
      ctx_type x;
      logic    fq;
      x = xi;
      if (!x.done) begin
         if (x.lc > LBL_MAX) begin
            x = f_fail(x, dnst_pkg::ST_LONG_LABEL);
         end else begin
            fq = (x.lc == '0);
            x  = f_emit(x, dnst_pkg::KIND_WRITE, x.ls, 8'(x.lc), dnst_pkg::ST_OK,
                        10'd0, 9'd0, 1'b0);
            x  = f_finish(x, term, fq);
         end
      end
      return x;
   endfunction

   // One plain character inside a label.
   function automatic ctx_type f_label_char(ctx_type xi, logic [7:0] c);
      ctx_type x;
      x = xi;
      if (!x.done) begin
         if (dnst_pkg::is_name(c)) begin
            x = f_append(x, c);
            if (x.ok) begin
               x = f_lab_inc(x);
               x = f_bump(x, 3'd1);
            end
         end else if (c == dnst_pkg::CH_DOT) begin
            if (x.lc == '0) begin
               x = f_fail(x, dnst_pkg::ST_EMPTY);
            end else if (x.lc > LBL_MAX) begin
               x = f_fail(x, dnst_pkg::ST_LONG_LABEL);
            end else begin
               x    = f_emit(x, dnst_pkg::KIND_WRITE, x.ls, 8'(x.lc), dnst_pkg::ST_OK,
                             10'd0, 9'd0, 1'b0);
               x.ls = x.wc[7:0];
               x    = f_append(x, dnst_pkg::CH_NUL);
               if (x.ok) begin
                  x.lc = '0;
                  x    = f_bump(x, 3'd1);
               end
            end
         end else if (c == dnst_pkg::CH_BACKSLASH) begin
            x.ph = dnst_pkg::PH_ESC0;
         end else begin
            x = f_close(x, c);
         end
      end
      return x;
   endfunction

   // A byte given by an escape; control characters are refused.
   function automatic ctx_type f_esc_byte(ctx_type xi, logic [7:0] b, logic [2:0] used);
      ctx_type x;
      x = xi;
      if (!x.done) begin
         if ((b < dnst_pkg::CH_SPACE) || (b == dnst_pkg::CH_DEL)) begin
            x = f_fail(x, dnst_pkg::ST_BAD_ESC);
         end else begin
            x = f_append(x, b);
            if (x.ok) begin
               x    = f_lab_inc(x);
               x    = f_bump(x, used);
               x.ph = dnst_pkg::PH_LABEL;
            end
         end
      end
      return x;
   endfunction

   // ---------------------------------------------------------------------
   // One character per pass
   // ---------------------------------------------------------------------

   assign fire   = item_valid && out_free;
   assign at_end = (item.action == dnst_pkg::ACT_END);
   assign ch     = item.text_char;

   // Value of a complete three-digit escape
   assign esc_val = 10'(held0_ff - dnst_pkg::CH_ZERO) * 10'd100 +
                    10'(held1_ff - dnst_pkg::CH_ZERO) * 10'd10 +
                    10'(ch - dnst_pkg::CH_ZERO);

   always_comb begin
      nx.ph   = phase_ff;
      nx.lc   = lc_ff;
      nx.ls   = ls_ff;
      nx.wc   = wc_ff;
      nx.cc   = cc_ff;
      nx.lim  = lim_ff;
      nx.done = 1'b0;
      nx.ok   = 1'b0;
      nx.n    = '0;
      nx.res  = '0;
      held0_in = held0_ff;
      held1_in = held1_ff;

      case (phase_ff)
         dnst_pkg::PH_START: begin
            if (!at_end && (ch == dnst_pkg::CH_DOT)) begin
               nx.ph = dnst_pkg::PH_DOT;
            end else begin
               nx.ls = nx.wc[7:0];
               nx    = f_append(nx, dnst_pkg::CH_NUL);
               if (nx.ok) begin
                  nx.ph = dnst_pkg::PH_LABEL;
                  nx.lc = '0;
                  if (at_end) nx = f_close(nx, dnst_pkg::CH_NUL);
                  else        nx = f_label_char(nx, ch);
               end
            end
         end
         dnst_pkg::PH_DOT: begin
            // A leading dot is the root name unless a label follows it.
            if (!at_end && dnst_pkg::is_name(ch)) begin
               nx.ls = nx.wc[7:0];
               nx    = f_append(nx, dnst_pkg::CH_NUL);
               if (nx.ok) nx = f_fail(nx, dnst_pkg::ST_EMPTY);
            end else begin
               nx = f_append(nx, dnst_pkg::CH_NUL);
               if (nx.ok) begin
                  nx = f_bump(nx, 3'd1);
                  nx = f_finish(nx, at_end ? dnst_pkg::CH_NUL : ch, 1'b1);
               end
            end
         end
         dnst_pkg::PH_LABEL: begin
            if (at_end) nx = f_close(nx, dnst_pkg::CH_NUL);
            else        nx = f_label_char(nx, ch);
         end
         dnst_pkg::PH_ESC0: begin
            if (at_end) begin
               nx = f_fail(nx, dnst_pkg::ST_BAD_ESC);
            end else if (dnst_pkg::is_digit(ch)) begin
               held0_in = ch;
               nx.ph    = dnst_pkg::PH_ESC1;
            end else begin
               nx = f_esc_byte(nx, ch, 3'd2);
            end
         end
         dnst_pkg::PH_ESC1: begin
            if (!at_end && dnst_pkg::is_digit(ch)) begin
               held1_in = ch;
               nx.ph    = dnst_pkg::PH_ESC2;
            end else begin
               // Not a three-digit escape: replay the held digit as a literal.
               nx = f_esc_byte(nx, held0_ff, 3'd2);
               if (at_end) nx = f_close(nx, dnst_pkg::CH_NUL);
               else        nx = f_label_char(nx, ch);
            end
         end
         dnst_pkg::PH_ESC2: begin
            if (!at_end && dnst_pkg::is_digit(ch)) begin
               if (esc_val > 10'd255) nx = f_fail(nx, dnst_pkg::ST_BAD_ESC);
               else                   nx = f_esc_byte(nx, esc_val[7:0], 3'd4);
            end else begin
               // Replay both held digits, then handle this character.
               nx = f_esc_byte(nx, held0_ff, 3'd2);
               nx = f_label_char(nx, held1_ff);
               if (at_end) nx = f_close(nx, dnst_pkg::CH_NUL);
               else        nx = f_label_char(nx, ch);
            end
         end
         default: begin
            nx = f_restart(nx);
         end
      endcase

      // Mark the final result of this character.
      for (int i = 0; i < dnst_pkg::MAX_RES; i++) begin
         nx.res[i].last = (dnst_pkg::CNT_W'(i) == (nx.n - dnst_pkg::CNT_W'(1)));
      end
   end

   assign burst.cnt = nx.n;
   assign burst.res = nx.res;

   // Limit above the buffer size acts as the buffer size.
   assign lim_in = (csr_wdata > WIRE_CAP) ? WIRE_CAP : csr_wdata;

   // Name state and wire limit
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dnst_pkg::PH_START;
         lc_ff    <= '0;
         ls_ff    <= '0;
         wc_ff    <= '0;
         cc_ff    <= '0;
         lim_ff   <= WIRE_CAP;
      end else begin
         if (fire) begin
            phase_ff <= nx.ph;
            lc_ff    <= nx.lc;
            ls_ff    <= nx.ls;
            wc_ff    <= nx.wc;
            cc_ff    <= nx.cc;
         end
         if (csr_we) begin
            lim_ff <= lim_in;
         end
      end
   end

   // Held escape digits are always written before they are read.
   always_ff @(posedge clock) begin
      if (fire) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

endmodule

// ===== rtl/core/dnst_out_seq.sv =====
module dnst_out_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  dnst_pkg::burst_type burst,
   output logic                out_free,
   dnst_rsp_if.source          rsp_chan
);

   logic [dnst_pkg::CNT_W-1:0]                cnt_ff;
   logic [dnst_pkg::CNT_W-1:0]                cnt_in;
   dnst_pkg::rsp_type [dnst_pkg::MAX_RES-1:0] res_ff;
   dnst_pkg::rsp_type [dnst_pkg::MAX_RES-1:0] res_in;
   logic                                      take;

   assign rsp_chan.valid = (cnt_ff != '0);
   assign take           = rsp_chan.valid && rsp_chan.ready;

   // Free for a new burst when empty or when its final result leaves now.
   assign out_free = (cnt_ff == '0) || (take && (cnt_ff == dnst_pkg::CNT_W'(1)));

   // The head of the burst is always the result on offer; a transfer shifts the rest down.
   always_comb begin
      cnt_in = cnt_ff;
      res_in = res_ff;
      if (load) begin
         cnt_in = burst.cnt;
         res_in = burst.res;
      end else if (take) begin
         cnt_in = cnt_ff - dnst_pkg::CNT_W'(1);
         for (int i = 0; i < dnst_pkg::MAX_RES - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_chan.kind            = res_ff[0].kind;
   assign rsp_chan.wire_addr       = res_ff[0].wire_addr;
   assign rsp_chan.wire_byte       = res_ff[0].wire_byte;
   assign rsp_chan.status          = res_ff[0].status;
   assign rsp_chan.chars_used      = res_ff[0].chars_used;
   assign rsp_chan.wire_length     = res_ff[0].wire_length;
   assign rsp_chan.fully_qualified = res_ff[0].fully_qualified;
   assign rsp_chan.last            = res_ff[0].last;

endmodule

// ===== rtl/core/dns_name_text_to_wire.sv =====
// A character waits in the input register until the parser takes it; all its results
// are then loaded at once into the result register, which offers them on rsp_chan.
// Throughput: one character per cycle while each causes at most one result and the
// receiver is ready; more results hold the output stage (at most 4 per character).
// Reset (synchronous) returns the parser to the start of a name and the wire limit to 256.
module dns_name_text_to_wire #(
   parameter int MAX_LABEL  = 63,
   parameter int WIRE_BYTES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   dnst_req_if.sink                      req_chan,
   dnst_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [dnst_pkg::LIMIT_W-1:0]  csr_wdata
);

   logic                item_valid;
   dnst_pkg::item_type  item;
   logic                step_fire;
   logic                out_free;
   dnst_pkg::burst_type burst;

   // Input holding register
   dnst_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (step_fire),
      .item_valid (item_valid),
      .item       (item)
   );

   // Parser: one character per pass, all its results at once
   dnst_step #(
      .MAX_LABEL  (MAX_LABEL),
      .WIRE_BYTES (WIRE_BYTES)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .fire       (step_fire),
      .burst      (burst)
   );

   // Result register, sending a burst one transfer at a time
   dnst_out_seq u_out_seq (
      .clock    (clock),
      .reset    (reset),
      .load     (step_fire),
      .burst    (burst),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

   // A burst that has further results keeps the response channel valid.
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last) |=> rsp_chan.valid)
      else $error("response burst broken before its final transfer");

   // A parsed character with results offers them in the next cycle.
   a_burst_shown: assert property (@(posedge clock) disable iff (reset)
      (step_fire && (burst.cnt != '0)) |=> rsp_chan.valid)
      else $error("loaded burst not offered");

   // A failed name reports no length, no qualification and no terminator.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == dnst_pkg::KIND_FINISH) &&
       (rsp_chan.status != dnst_pkg::ST_OK)) |->
      ((rsp_chan.wire_length == '0) && !rsp_chan.fully_qualified &&
       (rsp_chan.wire_byte == '0) && (rsp_chan.wire_addr == '0)))
      else $error("error finish carries stray fields");

   // A wire write carries no finish information.
   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == dnst_pkg::KIND_WRITE)) |->
      ((rsp_chan.status == dnst_pkg::ST_OK) && (rsp_chan.chars_used == '0) &&
       (rsp_chan.wire_length == '0) && !rsp_chan.fully_qualified))
      else $error("wire write carries finish fields");

endmodule

// ===== tb/sv/tb_dns_name_text_to_wire.sv =====
`timescale 1ns / 100ps

module tb_dns_name_text_to_wire;
   import dnst_pkg::*;

   localparam int MAX_LABEL      = 63;
   localparam int WIRE_BYTES     = 256;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 10;
   localparam int LONG_HOLD      = 80;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [LIMIT_W-1:0] csr_wdata;

   dnst_req_if req_chan ();
   dnst_rsp_if rsp_chan ();

   dns_name_text_to_wire #(
      .MAX_LABEL  (MAX_LABEL),
      .WIRE_BYTES (WIRE_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stimulus and expectation stores, with counters shared by the processes.
   item_type    text_items_pending[$];
   rsp_type     wire_results_due[$];
   rsp_type     step_results[$];
   int unsigned chars_queued   = 0;
   int unsigned chars_accepted = 0;
   int unsigned mismatch_count = 0;
   bit          req_taken      = 1'b0;
   bit          sender_idle_on = 1'b1;
   bit          receiver_idle_on = 1'b1;
   bit          hold_request   = 1'b0;
   int unsigned sender_gap     = 0;
   int unsigned receiver_hold  = 0;
   int unsigned quiet_cycles   = 0;

   // Predicted state of the converter.
   phase_type   parse_phase;
   int unsigned label_len;
   int unsigned label_pos;
   int unsigned wire_len;
   int unsigned chars_seen;
   int unsigned wire_cap;
   logic [CHAR_W-1:0] held_digit [0:1];
   bit          name_closed;

   function automatic bit char_digit(logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic bit char_name(logic [CHAR_W-1:0] c);
      return char_digit(c) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
             ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || (c == CH_HYPHEN) || (c == CH_USCORE);
   endfunction

   function automatic void put_result(logic kind, int unsigned addr, int unsigned data,
                                      logic [STAT_W-1:0] st, int unsigned used,
                                      int unsigned len, bit fq);
      rsp_type r;
      r.kind            = kind;
      r.wire_addr       = addr[ADDR_W-1:0];
      r.wire_byte       = data[CHAR_W-1:0];
      r.status          = st;
      r.chars_used      = used[USED_W-1:0];
      r.wire_length     = len[LEN_W-1:0];
      r.fully_qualified = fq;
      r.last            = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void name_restart();
      parse_phase = PH_START;
      label_len   = 0;
      label_pos   = 0;
      wire_len    = 0;
      chars_seen  = 0;
   endfunction

   function automatic void count_chars(int unsigned k);
      chars_seen += k;
      if (chars_seen > CHARS_MAX) begin
         chars_seen = CHARS_MAX;
      end
   endfunction

   function automatic void grow_label();
      if (label_len <= MAX_LABEL) begin
         label_len++;
      end
   endfunction

   function automatic void end_with_error(logic [STAT_W-1:0] st);
      put_result(KIND_FINISH, 0, 0, st, chars_seen, 0, 1'b0);
      name_restart();
      name_closed = 1'b1;
   endfunction

   function automatic void end_ok(int unsigned term, bit fq);
      put_result(KIND_FINISH, 0, term, ST_OK, chars_seen, wire_len, fq);
      name_restart();
      name_closed = 1'b1;
   endfunction

   // Appends one wire byte, or ends the name when the wire limit is reached.
   function automatic bit write_byte(int unsigned b);
      int unsigned cap;
      cap = (wire_cap > WIRE_BYTES) ? WIRE_BYTES : wire_cap;
      if (name_closed) begin
         return 1'b0;
      end
      if (wire_len >= cap) begin
         end_with_error(ST_LONG_NAME);
         return 1'b0;
      end
      put_result(KIND_WRITE, wire_len, b, ST_OK, 0, 0, 1'b0);
      wire_len++;
      return 1'b1;
   endfunction

   // Patches the open label's length and finishes the name.
   function automatic void close_name(int unsigned term);
      if (name_closed) begin
         return;
      end
      if (label_len > MAX_LABEL) begin
         end_with_error(ST_LONG_LABEL);
         return;
      end
      put_result(KIND_WRITE, label_pos, label_len, ST_OK, 0, 0, 1'b0);
      end_ok(term, label_len == 0);
   endfunction

   function automatic void take_label_char(logic [CHAR_W-1:0] c);
      if (name_closed) begin
         return;
      end
      if (char_name(c)) begin
         if (write_byte(c)) begin
            grow_label();
            count_chars(1);
         end
      end else if (c == CH_DOT) begin
         if (label_len == 0) begin
            end_with_error(ST_EMPTY);
         end else if (label_len > MAX_LABEL) begin
            end_with_error(ST_LONG_LABEL);
         end else begin
            put_result(KIND_WRITE, label_pos, label_len, ST_OK, 0, 0, 1'b0);
            label_pos = wire_len;
            if (write_byte(CH_NUL)) begin
               label_len = 0;
               count_chars(1);
            end
         end
      end else if (c == CH_BACKSLASH) begin
         parse_phase = PH_ESC0;
      end else begin
         close_name(c);
      end
   endfunction

   function automatic void take_escaped(int unsigned v, int unsigned used);
      if (name_closed) begin
         return;
      end
      if (v < CH_SPACE || v == CH_DEL) begin
         end_with_error(ST_BAD_ESC);
         return;
      end
      if (write_byte(v)) begin
         grow_label();
         count_chars(used);
         parse_phase = PH_LABEL;
      end
   endfunction

   // Works out every result that one accepted text item causes.
   function automatic void parse_text_item(logic act, logic [CHAR_W-1:0] c);
      bit          at_end;
      int unsigned v;
      at_end = (act == ACT_END);
      name_closed = 1'b0;
      step_results.delete();
      case (parse_phase)
         PH_START: begin
            if (!at_end && c == CH_DOT) begin
               parse_phase = PH_DOT;
            end else begin
               label_pos = wire_len;
               if (write_byte(CH_NUL)) begin
                  parse_phase = PH_LABEL;
                  label_len = 0;
                  if (at_end) close_name(CH_NUL);
                  else take_label_char(c);
               end
            end
         end
         PH_DOT: begin
            if (!at_end && char_name(c)) begin
               label_pos = wire_len;
               if (write_byte(CH_NUL)) end_with_error(ST_EMPTY);
            end else if (write_byte(CH_NUL)) begin
               count_chars(1);
               end_ok(at_end ? CH_NUL : c, 1'b1);
            end
         end
         PH_LABEL: begin
            if (at_end) close_name(CH_NUL);
            else take_label_char(c);
         end
         PH_ESC0: begin
            if (at_end) begin
               end_with_error(ST_BAD_ESC);
            end else if (char_digit(c)) begin
               held_digit[0] = c;
               parse_phase = PH_ESC1;
            end else begin
               take_escaped(c, 2);
            end
         end
         PH_ESC1: begin
            if (!at_end && char_digit(c)) begin
               held_digit[1] = c;
               parse_phase = PH_ESC2;
            end else begin
               take_escaped(held_digit[0], 2);
               if (at_end) close_name(CH_NUL);
               else take_label_char(c);
            end
         end
         PH_ESC2: begin
            if (!at_end && char_digit(c)) begin
               v = (int'(held_digit[0]) - int'(CH_ZERO)) * 100 +
                   (int'(held_digit[1]) - int'(CH_ZERO)) * 10 + (int'(c) - int'(CH_ZERO));
               if (v > 255) end_with_error(ST_BAD_ESC);
               else take_escaped(v, 4);
            end else begin
               take_escaped(held_digit[0], 2);
               take_label_char(held_digit[1]);
               if (at_end) close_name(CH_NUL);
               else take_label_char(c);
            end
         end
         default: begin
            name_restart();
         end
      endcase
      if (step_results.size() > 0) begin
         step_results[step_results.size() - 1].last = 1'b1;
      end
      foreach (step_results[i]) begin
         wire_results_due.push_back(step_results[i]);
      end
   endfunction

   function automatic void check_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
         mismatch_count++;
      end
   endfunction

   // Input transfers feed the predictor; output transfers are checked against it.
   always @(posedge clock) begin
      rsp_type want;
      req_taken = 1'b0;
      if (reset) begin
         name_restart();
         wire_cap = WIRE_BYTES;
         wire_results_due.delete();
      end else begin
         if (csr_we) begin
            wire_cap = csr_wdata;
         end
         if (req_chan.valid && req_chan.ready) begin
            req_taken = 1'b1;
            chars_accepted++;
            parse_text_item(req_chan.action, req_chan.text_char);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (wire_results_due.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual kind %0d addr %0d byte %0d",
                        $time, rsp_chan.kind, rsp_chan.wire_addr, rsp_chan.wire_byte);
               mismatch_count++;
            end else begin
               want = wire_results_due.pop_front();
               check_field("kind", want.kind, rsp_chan.kind);
               check_field("wire_addr", want.wire_addr, rsp_chan.wire_addr);
               check_field("wire_byte", want.wire_byte, rsp_chan.wire_byte);
               check_field("status", want.status, rsp_chan.status);
               check_field("chars_used", want.chars_used, rsp_chan.chars_used);
               check_field("wire_length", want.wire_length, rsp_chan.wire_length);
               check_field("fully_qualified", want.fully_qualified, rsp_chan.fully_qualified);
               check_field("last", want.last, rsp_chan.last);
            end
         end
      end
   end

   // Sender: offers pending text items, with random gaps between transfers.
   always @(negedge clock) begin
      item_type it;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_taken) begin
         // Hold the offered item until its transfer.
      end else if (sender_gap > 0) begin
         sender_gap--;
         req_chan.valid <= 1'b0;
      end else if (sender_idle_on && text_items_pending.size() > 0 &&
                   $urandom_range(0, 5) == 0) begin
         sender_gap = $urandom_range(1, 19) - 1;
         req_chan.valid <= 1'b0;
      end else if (text_items_pending.size() > 0) begin
         it = text_items_pending.pop_front();
         req_chan.valid     <= 1'b1;
         req_chan.action    <= it.action;
         req_chan.text_char <= it.text_char;
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         receiver_hold = LONG_HOLD - 1;
         rsp_chan.ready <= 1'b0;
      end else if (receiver_hold > 0) begin
         receiver_hold--;
         rsp_chan.ready <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
         receiver_hold = $urandom_range(1, 19) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic push_item(logic act, logic [CHAR_W-1:0] c);
      item_type it;
      it.action    = act;
      it.text_char = c;
      text_items_pending.push_back(it);
      chars_queued++;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         push_item(ACT_CHAR, s[i]);
      end
   endtask

   function automatic logic [CHAR_W-1:0] pick_name_char();
      int unsigned r;
      r = $urandom_range(0, 63);
      if (r < 10) return CH_ZERO + r;
      if (r < 36) return CH_UP_A + (r - 10);
      if (r < 62) return CH_LOW_A + (r - 36);
      if (r == 62) return CH_HYPHEN;
      return CH_USCORE;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_terminator();
      logic [CHAR_W-1:0] c;
      do begin
         c = $urandom_range(0, 255);
      end while (char_name(c) || c == CH_DOT || c == CH_BACKSLASH);
      return c;
   endfunction

   // Mostly well-formed names with random labels and escapes; the rest is noise.
   task automatic queue_random_name();
      int unsigned labels;
      int unsigned len;
      int unsigned v;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 6)) begin
            push_item($urandom_range(0, 1), $urandom_range(0, 255));
         end
         return;
      end
      labels = $urandom_range(1, 3);
      for (int k = 0; k < labels; k++) begin
         case ($urandom_range(0, 19))
            0:       len = 0;
            1:       len = $urandom_range(62, 65);
            default: len = $urandom_range(1, 6);
         endcase
         for (int j = 0; j < len; j++) begin
            case ($urandom_range(0, 15))
               0: begin
                  v = $urandom_range(0, 299);
                  push_item(ACT_CHAR, CH_BACKSLASH);
                  push_item(ACT_CHAR, CH_ZERO + v / 100);
                  push_item(ACT_CHAR, CH_ZERO + (v / 10) % 10);
                  push_item(ACT_CHAR, CH_ZERO + v % 10);
               end
               1: begin
                  push_item(ACT_CHAR, CH_BACKSLASH);
                  push_item(ACT_CHAR, $urandom_range(0, 255));
               end
               2: begin
                  // A short digit escape, settled by whatever follows.
                  push_item(ACT_CHAR, CH_BACKSLASH);
                  repeat ($urandom_range(1, 2)) push_item(ACT_CHAR, CH_ZERO + $urandom_range(0, 9));
               end
               default: push_item(ACT_CHAR, pick_name_char());
            endcase
         end
         if (k + 1 < labels || $urandom_range(0, 1) == 1) begin
            push_item(ACT_CHAR, CH_DOT);
         end
      end
      if ($urandom_range(0, 1) == 0) push_item(ACT_END, $urandom_range(0, 255));
      else push_item(ACT_CHAR, pick_terminator());
   endtask

   task automatic queue_random_names(int unsigned count);
      int unsigned first;
      first = chars_queued;
      while (chars_queued - first < count) begin
         queue_random_name();
      end
   endtask

   // Waits until every queued item has been taken and every result has come.
   task automatic wait_all_done();
      do @(negedge clock);
      while (chars_accepted != chars_queued || wire_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(int unsigned v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v[LIMIT_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.action    = ACT_CHAR;
      req_chan.text_char = CH_NUL;
      rsp_chan.ready     = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed names at the reset limit.
      push_item(ACT_END, CH_NUL);
      push_text(".");
      push_item(ACT_END, 8'hFF);
      push_text(".a");
      push_text("..");
      push_text("z9_-.");
      push_item(ACT_CHAR, 8'hFF);
      push_text("\\065");
      push_item(ACT_END, CH_NUL);
      push_text("\\256");
      push_text("\\");
      push_item(ACT_CHAR, CH_DEL);
      push_text("\\");
      push_item(ACT_END, CH_NUL);
      push_text("\\12");
      push_item(ACT_END, CH_NUL);
      push_text("a..");
      wait_all_done();

      // Limit of one: one byte fits, a second one overflows.
      write_limit(1);
      push_text("a");
      push_item(ACT_END, CH_NUL);
      wait_all_done();

      // A zero limit makes every name overflow.
      write_limit(0);
      push_item(ACT_END, CH_NUL);
      push_text(".");
      push_item(ACT_END, CH_NUL);
      wait_all_done();

      // Oversized limit with a long receiver hold-off while items keep coming.
      write_limit(511);
      sender_idle_on = 1'b0;
      hold_request   = 1'b1;
      for (int i = 0; i < 64; i++) push_item(ACT_CHAR, pick_name_char());
      push_item(ACT_END, CH_NUL);
      queue_random_names(30);
      wait_all_done();
      sender_idle_on = 1'b1;

      write_limit($urandom_range(8, 40));
      queue_random_names(35);
      wait_all_done();

      write_limit(WIRE_BYTES);
      queue_random_names(35);
      wait_all_done();

      // Last stretch without idling on either side.
      write_limit(16);
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      queue_random_names(30);
      wait_all_done();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== dns_name_text_to_wire.f =====
rtl/core/dnst_pkg.sv
rtl/core/dnst_req_if.sv
rtl/core/dnst_rsp_if.sv
rtl/core/dnst_in_reg.sv
rtl/core/dnst_step.sv
rtl/core/dnst_out_seq.sv
rtl/core/dns_name_text_to_wire.sv
tb/sv/tb_dns_name_text_to_wire.sv
